### hdl/ssbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssbs_pkg: shared types and constants for the SPI SRAM burst sequencer
// Action and error codes, result slot numbering and the command record that
// the front end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package ssbs_pkg;

  localparam int unsigned BankWordsLog2Default = 17;

  localparam int unsigned ActionW = 3;
  localparam int unsigned AddrW   = 18;
  localparam int unsigned CountW  = 19;
  localparam int unsigned DataW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BaW     = 24;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] ReadOpcodeReset  = 8'h03;
  localparam logic [ByteW-1:0] WriteOpcodeReset = 8'h02;

  localparam int unsigned QueueDepth = 2;  // power of two
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [ActionW-1:0] {
    ActRead  = 3'd0,
    ActWrite = 3'd1,
    ActFill  = 3'd2,
    ActWord  = 3'd3,
    ActMiso  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ErrNone  = 2'd0,
    ErrRange = 2'd1,
    ErrPhase = 2'd2
  } err_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegReadOpcode  = 1'b0,
    RegWriteOpcode = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhRead  = 2'd1,
    PhWrite = 2'd2,
    PhFill  = 2'd3
  } phase_e;

  // Result slots, emitted in ascending order.
  localparam int unsigned SlotErr   = 0;   // error-only result
  localparam int unsigned SlotLo    = 1;   // write word low byte
  localparam int unsigned SlotHi    = 2;   // write word high byte
  localparam int unsigned SlotCapHi = 3;   // capture frame for a high byte
  localparam int unsigned SlotWord  = 4;   // assembled read word
  localparam int unsigned SlotOpc   = 5;   // opcode frame
  localparam int unsigned SlotA2    = 6;
  localparam int unsigned SlotA1    = 7;
  localparam int unsigned SlotA0    = 8;
  localparam int unsigned SlotDummy = 9;
  localparam int unsigned SlotCap   = 10;  // capture frame for a low byte
  localparam int unsigned NumSlots  = 11;
  localparam int unsigned SlotIdxW  = $clog2(NumSlots);

  typedef logic [NumSlots-1:0] slot_mask_t;

  localparam slot_mask_t OpenWrMask = slot_mask_t'((1 << SlotOpc) | (1 << SlotA2) |
                                                   (1 << SlotA1) | (1 << SlotA0));
  localparam slot_mask_t OpenRdMask = OpenWrMask |
                                      slot_mask_t'((1 << SlotDummy) | (1 << SlotCap));

  typedef struct packed {
    slot_mask_t        slots;
    err_e              err;
    logic              chip_a;   // chip for word/capture frames
    logic              chip_b;   // chip for header frames and trailing capture
    logic              rel;      // release after the pre-header segment
    logic [DataW-1:0]  word;     // write word or assembled read word
    logic [ByteW-1:0]  opcode;
    logic [BaW-1:0]    ba;
  } cmd_t;

endpackage
`default_nettype wire

### hdl/ssbs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssbs_front: item intake and classification
// Holds the burst state and opcode registers, checks each item against the
// phase and range, and turns it into one command for the back end.
// ----------------------------------------------------------------------------
module ssbs_front #(
  parameter int unsigned BANK_WORDS_LOG2 = ssbs_pkg::BankWordsLog2Default
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [ssbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [ssbs_pkg::ByteW-1:0]     cfg_data_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [ssbs_pkg::ActionW-1:0]   action_i,
  input  wire [ssbs_pkg::AddrW-1:0]     word_address_i,
  input  wire [ssbs_pkg::CountW-1:0]    word_count_i,
  input  wire [ssbs_pkg::DataW-1:0]     data_i,
  input  wire                           q_full_i,
  output logic                          q_push_o,
  output ssbs_pkg::cmd_t                q_cmd_o
);
  import ssbs_pkg::*;

  localparam int unsigned SumW = (BANK_WORDS_LOG2 + 2 > 20) ? BANK_WORDS_LOG2 + 2 : 20;
  localparam logic [SumW-1:0] Bank = SumW'(1) << BANK_WORDS_LOG2;

  phase_e              phase_q, phase_d;
  logic [AddrW-1:0]    cw_q, cw_d;
  logic [CountW-1:0]   wl_q, wl_d;
  logic                chip_q, chip_d;
  logic [DataW-1:0]    fill_q, fill_d;
  logic [ByteW-1:0]    hold_q, hold_d;
  logic                hi_q, hi_d;
  logic [ByteW-1:0]    rd_opc_q, wr_opc_q;

  logic                accept;
  logic [AddrW-1:0]    cw_nx;
  logic [CountW-1:0]   wl_nx;
  logic                seg_end, reopen, range_bad;
  logic [DataW-1:0]    wr_word;
  cmd_t                cmd;

  function automatic logic [BaW-1:0] chip_byte_ofs(input logic [AddrW-1:0] cw);
    logic [31:0] ofs;
    ofs = 32'(cw) & ((32'd1 << BANK_WORDS_LOG2) - 32'd1);
    return {ofs[BaW-2:0], 1'b0};
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;
  assign q_cmd_o    = cmd;

  assign cw_nx     = cw_q + AddrW'(1);
  assign wl_nx     = wl_q - CountW'(1);
  assign seg_end   = (wl_q <= CountW'(1)) || (!chip_q && SumW'(cw_q) == Bank - SumW'(1));
  assign reopen    = (wl_nx != '0) && !chip_q && SumW'(cw_nx) == Bank;
  assign range_bad = (word_count_i == '0) ||
                     (SumW'(word_address_i) + SumW'(word_count_i) > (Bank << 1));
  assign wr_word   = (phase_q == PhFill) ? fill_q : data_i;

  always_comb begin
    phase_d = phase_q;
    cw_d    = cw_q;
    wl_d    = wl_q;
    chip_d  = chip_q;
    fill_d  = fill_q;
    hold_d  = hold_q;
    hi_d    = hi_q;
    cmd        = '0;
    cmd.err    = ErrNone;
    cmd.chip_a = chip_q;
    cmd.chip_b = chip_q;
    cmd.rel    = seg_end;
    case (action_i) inside
      ActRead, ActWrite, ActFill: begin
        if (phase_q != PhIdle) begin
          cmd.err   = ErrPhase;
          cmd.slots = slot_mask_t'(1 << SlotErr);
        end else if (range_bad) begin
          cmd.err   = ErrRange;
          cmd.slots = slot_mask_t'(1 << SlotErr);
        end else begin
          cw_d       = word_address_i;
          wl_d       = word_count_i;
          chip_d     = SumW'(word_address_i) >= Bank;
          hi_d       = 1'b0;
          cmd.chip_b = SumW'(word_address_i) >= Bank;
          cmd.ba     = chip_byte_ofs(word_address_i);
          if (action_i == ActRead) begin
            phase_d    = PhRead;
            cmd.slots  = OpenRdMask;
            cmd.opcode = rd_opc_q;
          end else begin
            if (action_i == ActFill) begin
              fill_d = data_i;
            end
            phase_d    = (action_i == ActWrite) ? PhWrite : PhFill;
            cmd.slots  = OpenWrMask;
            cmd.opcode = wr_opc_q;
          end
        end
      end
      ActWord: begin
        if (phase_q == PhWrite || phase_q == PhFill) begin
          cmd.word  = wr_word;
          cmd.slots = slot_mask_t'((1 << SlotLo) | (1 << SlotHi));
          wl_d = wl_nx;
          cw_d = cw_nx;
          if (wl_nx == '0) begin
            phase_d = PhIdle;
          end else if (reopen) begin
            chip_d     = 1'b1;
            cmd.chip_b = 1'b1;
            cmd.ba     = chip_byte_ofs(cw_nx);
            cmd.opcode = wr_opc_q;
            cmd.slots  = cmd.slots | OpenWrMask;
          end
        end else begin
          cmd.err   = ErrPhase;
          cmd.slots = slot_mask_t'(1 << SlotErr);
        end
      end
      ActMiso: begin
        if (phase_q == PhRead) begin
          if (!hi_q) begin
            hold_d    = data_i[ByteW-1:0];
            hi_d      = 1'b1;
            cmd.slots = slot_mask_t'(1 << SlotCapHi);
          end else begin
            hi_d      = 1'b0;
            cmd.word  = {data_i[ByteW-1:0], hold_q};
            cmd.slots = slot_mask_t'(1 << SlotWord);
            wl_d = wl_nx;
            cw_d = cw_nx;
            if (wl_nx == '0) begin
              phase_d = PhIdle;
            end else if (reopen) begin
              chip_d     = 1'b1;
              cmd.chip_b = 1'b1;
              cmd.ba     = chip_byte_ofs(cw_nx);
              cmd.opcode = rd_opc_q;
              cmd.slots  = cmd.slots | OpenRdMask;
            end else begin
              cmd.slots = cmd.slots | slot_mask_t'(1 << SlotCap);
            end
          end
        end else begin
          cmd.err   = ErrPhase;
          cmd.slots = slot_mask_t'(1 << SlotErr);
        end
      end
      default: begin
        cmd.err   = ErrPhase;
        cmd.slots = slot_mask_t'(1 << SlotErr);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cw_q    <= '0;
      wl_q    <= '0;
      chip_q  <= 1'b0;
      fill_q  <= '0;
      hold_q  <= '0;
      hi_q    <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cw_q    <= cw_d;
      wl_q    <= wl_d;
      chip_q  <= chip_d;
      fill_q  <= fill_d;
      hold_q  <= hold_d;
      hi_q    <= hi_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_opc_q <= ReadOpcodeReset;
      wr_opc_q <= WriteOpcodeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegReadOpcode:  rd_opc_q <= cfg_data_i;
        RegWriteOpcode: wr_opc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a burst in progress always has words left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhIdle |-> wl_q != '0)
    else $error("busy phase with no words left");

  // high-byte expectation only exists while reading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_q |-> phase_q == PhRead)
    else $error("expect_high set outside a read");

  // a reopen always lands on chip 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && reopen && (cmd.slots & OpenWrMask) != '0 && action_i != ActRead &&
      action_i != ActWrite && action_i != ActFill |=> chip_q)
    else $error("reopen did not select chip 1");

endmodule
`default_nettype wire

### hdl/ssbs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssbs_queue: command queue between front and back end
// Small register FIFO; the head entry is visible to the back end.
// ----------------------------------------------------------------------------
module ssbs_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  ssbs_pkg::cmd_t  push_cmd_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            empty_o,
  output ssbs_pkg::cmd_t  head_o
);
  import ssbs_pkg::*;

  cmd_t              mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QueueDepth))
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i |-> !full_o) and (pop_i |-> !empty_o))
    else $error("queue push when full or pop when empty");

endmodule
`default_nettype wire

### hdl/ssbs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssbs_back: result sequencer
// Walks the slot mask of each command in order and drives one result beat
// per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module ssbs_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          q_empty_i,
  input  ssbs_pkg::cmd_t               q_head_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         frame_valid_o,
  output logic                         chip_o,
  output logic [ssbs_pkg::ByteW-1:0]   mosi_byte_o,
  output logic                         capture_o,
  output logic                         release_res_o,
  output logic                         word_valid_o,
  output logic [ssbs_pkg::DataW-1:0]   read_word_o,
  output logic [1:0]                   error_o,
  output logic                         last_o
);
  import ssbs_pkg::*;

  cmd_t                 cur_q;
  slot_mask_t           mask_q;
  logic                 out_valid_q;

  logic                 use_head, have, load;
  cmd_t                 c;
  slot_mask_t           eff, sel, rem;
  logic [SlotIdxW-1:0]  idx;

  logic                 fv_d, chip_d, cap_d, rel_d, wv_d;
  logic [ByteW-1:0]     mosi_d;
  logic [DataW-1:0]     word_d;
  logic [1:0]           err_d;

  assign use_head = mask_q == '0;
  assign have     = !use_head || !q_empty_i;
  assign load     = have && (!out_valid_q || !out_stall_i);
  assign q_pop_o  = load && use_head;
  assign c        = use_head ? q_head_i : cur_q;
  assign eff      = use_head ? q_head_i.slots : mask_q;
  assign sel      = eff & (~eff + slot_mask_t'(1));
  assign rem      = eff & ~sel;

  always_comb begin
    idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (sel[i]) begin
        idx = SlotIdxW'(i);
      end
    end
  end

  always_comb begin
    fv_d   = 1'b1;
    chip_d = c.chip_b;
    mosi_d = '0;
    cap_d  = 1'b0;
    rel_d  = 1'b0;
    wv_d   = 1'b0;
    word_d = '0;
    err_d  = ErrNone;
    unique case (idx)
      SlotIdxW'(SlotErr): begin
        fv_d   = 1'b0;
        chip_d = 1'b0;
        err_d  = c.err;
      end
      SlotIdxW'(SlotLo): begin
        chip_d = c.chip_a;
        mosi_d = c.word[ByteW-1:0];
      end
      SlotIdxW'(SlotHi): begin
        chip_d = c.chip_a;
        mosi_d = c.word[DataW-1:ByteW];
        rel_d  = c.rel;
      end
      SlotIdxW'(SlotCapHi): begin
        chip_d = c.chip_a;
        cap_d  = 1'b1;
        rel_d  = c.rel;
      end
      SlotIdxW'(SlotWord): begin
        fv_d   = 1'b0;
        chip_d = 1'b0;
        wv_d   = 1'b1;
        word_d = c.word;
      end
      SlotIdxW'(SlotOpc):   mosi_d = c.opcode;
      SlotIdxW'(SlotA2):    mosi_d = c.ba[23:16];
      SlotIdxW'(SlotA1):    mosi_d = c.ba[15:8];
      SlotIdxW'(SlotA0):    mosi_d = c.ba[7:0];
      SlotIdxW'(SlotDummy): mosi_d = '0;
      SlotIdxW'(SlotCap):   cap_d  = 1'b1;
      default: begin
        fv_d   = 1'b0;
        chip_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        mask_q <= rem;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && use_head) begin
      cur_q <= q_head_i;
    end
    if (load) begin
      frame_valid_o <= fv_d;
      chip_o        <= chip_d;
      mosi_byte_o   <= mosi_d;
      capture_o     <= cap_d;
      release_res_o <= rel_d;
      word_valid_o  <= wv_d;
      read_word_o   <= word_d;
      error_o       <= err_d;
      last_o        <= rem == '0;
    end
  end

  assign out_valid_o = out_valid_q;

  // an error result stands alone and is never a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o != ErrNone |-> !frame_valid_o && last_o && !word_valid_o)
    else $error("error beat carries other content");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (capture_o || release_res_o) |-> frame_valid_o)
    else $error("capture or release on a non-frame beat");

  // the head is only taken once the current command is fully sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> mask_q == '0 && !q_empty_i)
    else $error("pop while a command is still in flight");

endmodule
`default_nettype wire

### hdl/spi_sram_burst_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_sram_burst_sequencer: burst sequencer for two serial SPI SRAM chips
// Turns read/write/fill requests and returned MISO bytes into SPI byte frames
// and assembled read words over a word space split across two chips.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per beat: start
//   read, start write, start fill, next write word or a returned MISO byte.
//   Output channel (out_valid_o / out_stall_i) gives one result per beat; an
//   item yields 1 to 7 results and last_o marks its final one.
//   The front end classifies an item in the cycle it is accepted and queues
//   one command; the back end sends one result per cycle while the output
//   is not stalled. The first result of an item goes through the command
//   queue and is then registered on the output, once the queue holds no
//   earlier command and the output register is free.
//   A new item is taken every cycle while the two-entry command queue has
//   room, including while the output is stalled.
//   When the receiver stalls, the output beat holds; once the queue is full
//   in_stall_o rises.
//   Opcode registers are to be written through cfg_we_i / cfg_index_i /
//   cfg_data_i only while the block is idle; the block does not enforce this.
//   Reset returns to idle with opcodes 0x03 (read) and 0x02 (write).
// ----------------------------------------------------------------------------
module spi_sram_burst_sequencer #(
  parameter int unsigned BANK_WORDS_LOG2 = ssbs_pkg::BankWordsLog2Default
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [ssbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [ssbs_pkg::ByteW-1:0]     cfg_data_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [ssbs_pkg::ActionW-1:0]   action_i,
  input  wire [ssbs_pkg::AddrW-1:0]     word_address_i,
  input  wire [ssbs_pkg::CountW-1:0]    word_count_i,
  input  wire [ssbs_pkg::DataW-1:0]     data_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic                          frame_valid_o,
  output logic                          chip_o,
  output logic [ssbs_pkg::ByteW-1:0]    mosi_byte_o,
  output logic                          capture_o,
  output logic                          release_res_o,
  output logic                          word_valid_o,
  output logic [ssbs_pkg::DataW-1:0]    read_word_o,
  output logic [1:0]                    error_o,
  output logic                          last_o
);
  import ssbs_pkg::*;

  logic  q_full, q_push, q_empty, q_pop;
  cmd_t  push_cmd, head_cmd;

  ssbs_front #(
    .BANK_WORDS_LOG2(BANK_WORDS_LOG2)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .word_address_i (word_address_i),
    .word_count_i   (word_count_i),
    .data_i         (data_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  ssbs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (head_cmd)
  );

  ssbs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (head_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_valid_o (frame_valid_o),
    .chip_o        (chip_o),
    .mosi_byte_o   (mosi_byte_o),
    .capture_o     (capture_o),
    .release_res_o (release_res_o),
    .word_valid_o  (word_valid_o),
    .read_word_o   (read_word_o),
    .error_o       (error_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire
